// ===== rtl/msp_pkg.sv =====
// msp_pkg: shared types, sizes and codes for the multi-stack shared-pool unit.
// No dependencies; used by multi_stack_shared_pool_unit.
package msp_pkg;

	// Sizes
	localparam int NUM_STACKS = 3;
	localparam int POOL_DEPTH = 256;
	localparam int IDX_W      = $clog2(POOL_DEPTH);
	localparam int LINK_W     = IDX_W + 1;
	// Link value that marks "no node"
	localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(POOL_DEPTH);

	typedef enum logic {
		OP_PUSH = 1'b0,
		OP_POP  = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// Request transaction
	typedef struct packed {
		op_t               op;
		logic [1:0]        stack_sel;
		logic signed [31:0] entry_id;
		logic signed [31:0] entry_grade;
	} req_t;

	// Response transaction
	typedef struct packed {
		status_t            status;
		logic signed [31:0] popped_id;
		logic signed [31:0] popped_grade;
	} rsp_t;

endpackage

// ===== rtl/multi_stack_shared_pool_unit.sv =====
// multi_stack_shared_pool_unit: several LIFO stacks linked through one shared node pool.
// Depends on msp_pkg (sizes, op/status codes, request and response structs).
//
//   channel | valid     | ready     | payload
//   request | req_valid | req_ready | req (msp_pkg::req_t)
//   result  | rsp_valid | rsp_ready | rsp (msp_pkg::rsp_t)
//
// One transaction per cycle sustained while results are taken; a request passes the
// input register, then the result register. Each stack's top entry and link, and the
// free head's link, are cached in flops and refilled from the node memories after
// they change; the refill is forwarded from the read register, so no operation waits.
// Reset clears stack valid bits, the free head and the never-used mark; node memories
// are not cleared. When rsp_ready is low the result register holds, the input
// register fills, and req_ready then drops until the result is taken.
module multi_stack_shared_pool_unit (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  msp_pkg::req_t  req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output msp_pkg::rsp_t  rsp
);

	localparam int NS     = msp_pkg::NUM_STACKS;
	localparam int IDX_W  = msp_pkg::IDX_W;
	localparam int LINK_W = msp_pkg::LINK_W;

	// Node memories
	logic [63:0]       entry_mem [msp_pkg::POOL_DEPTH];
	logic [LINK_W-1:0] next_mem  [msp_pkg::POOL_DEPTH];

	// Input register
	logic          valid_s1;
	msp_pkg::req_t req_s1;

	// Result register
	logic          rsp_valid_q;
	msp_pkg::rsp_t rsp_q;

	// Stack state and caches
	logic [NS-1:0]     top_valid_q;
	logic [IDX_W-1:0]  top_ptr_q   [NS];
	logic [63:0]       top_entry_q [NS];
	logic [LINK_W-1:0] top_next_q  [NS];

	// Free list state
	logic [LINK_W-1:0] free_head_q;
	logic [LINK_W-1:0] free_next_q;
	logic [LINK_W-1:0] mark_q;

	// Refill read registers and their targets
	logic [63:0]       rd_entry_q;
	logic [LINK_W-1:0] rd_next_q;
	logic              pend_free_q;
	logic [NS-1:0]     pend_stk_q;

	// Datapath
	logic              fire;
	logic [NS-1:0]     sel_hit;
	logic              sel_ok;
	logic              cur_valid;
	logic [IDX_W-1:0]  cur_ptr;
	logic [63:0]       cur_entry;
	logic [LINK_W-1:0] cur_next;
	logic [LINK_W-1:0] free_next_eff;
	logic              free_avail;
	logic              push_ok;
	logic              pop_ok;
	logic              use_free;
	logic [IDX_W-1:0]  new_node;
	logic [LINK_W-1:0] push_link;
	logic [63:0]       push_entry;
	msp_pkg::rsp_t     res;

	// Memory ports
	logic              ent_we;
	logic              nxt_we;
	logic [IDX_W-1:0]  wr_addr;
	logic [LINK_W-1:0] wr_next;
	logic              rd_ent_en;
	logic              rd_nxt_en;
	logic [IDX_W-1:0]  rd_addr;

	// Handshake
	assign fire      = valid_s1 && (!rsp_valid_q || rsp_ready);
	assign req_ready = !valid_s1 || fire;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Selected stack, with forwarding from a pending refill
	always_comb begin
		sel_ok    = int'(req_s1.stack_sel) < NS;
		cur_valid = 1'b0;
		cur_ptr   = '0;
		cur_entry = '0;
		cur_next  = msp_pkg::LINK_NULL;
		for (int s = 0; s < NS; s++) begin
			sel_hit[s] = sel_ok && (int'(req_s1.stack_sel) == s);
			if (sel_hit[s]) begin
				cur_valid = top_valid_q[s];
				cur_ptr   = top_ptr_q[s];
				cur_entry = pend_stk_q[s] ? rd_entry_q : top_entry_q[s];
				cur_next  = pend_stk_q[s] ? rd_next_q : top_next_q[s];
			end
		end
	end

	// Operation decode and result
	always_comb begin
		free_next_eff = pend_free_q ? rd_next_q : free_next_q;
		free_avail    = free_head_q != msp_pkg::LINK_NULL;
		use_free      = free_avail;
		new_node      = free_avail ? free_head_q[IDX_W-1:0] : mark_q[IDX_W-1:0];
		push_ok       = (req_s1.op == msp_pkg::OP_PUSH) && sel_ok &&
		                (free_avail || mark_q != msp_pkg::LINK_NULL);
		pop_ok        = (req_s1.op == msp_pkg::OP_POP) && cur_valid;
		push_link     = cur_valid ? {1'b0, cur_ptr} : msp_pkg::LINK_NULL;
		push_entry    = {req_s1.entry_grade, req_s1.entry_id};

		res.status       = msp_pkg::ST_OK;
		res.popped_id    = '0;
		res.popped_grade = '0;
		if (req_s1.op == msp_pkg::OP_PUSH) begin
			if (sel_ok && !push_ok) begin
				res.status = msp_pkg::ST_FULL;
			end
		end else if (!pop_ok) begin
			res.status = msp_pkg::ST_EMPTY;
		end else begin
			res.popped_id    = cur_entry[31:0];
			res.popped_grade = cur_entry[63:32];
		end
	end

	// Memory write and refill read requests
	always_comb begin
		ent_we    = fire && push_ok;
		nxt_we    = fire && (push_ok || pop_ok);
		wr_addr   = pop_ok ? cur_ptr : new_node;
		wr_next   = pop_ok ? free_head_q : push_link;
		rd_ent_en = fire && pop_ok && (cur_next != msp_pkg::LINK_NULL);
		rd_nxt_en = rd_ent_en ||
		            (fire && push_ok && use_free && (free_next_eff != msp_pkg::LINK_NULL));
		rd_addr   = pop_ok ? cur_next[IDX_W-1:0] : free_next_eff[IDX_W-1:0];
	end

	// Node memory writes
	always_ff @(posedge clk) begin
		if (ent_we) begin
			entry_mem[wr_addr] <= push_entry;
		end
		if (nxt_we) begin
			next_mem[wr_addr] <= wr_next;
		end
	end

	// Node memory reads
	always_ff @(posedge clk) begin
		if (rd_ent_en) begin
			rd_entry_q <= entry_mem[rd_addr];
		end
		if (rd_nxt_en) begin
			rd_next_q <= next_mem[rd_addr];
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
			top_valid_q <= '0;
			free_head_q <= msp_pkg::LINK_NULL;
			mark_q      <= '0;
			pend_free_q <= 1'b0;
			pend_stk_q  <= '0;
		end else begin
			if (req_ready) begin
				valid_s1 <= req_valid;
			end
			if (fire) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			pend_free_q <= 1'b0;
			pend_stk_q  <= '0;
			if (fire && push_ok) begin
				if (use_free) begin
					free_head_q <= free_next_eff;
					pend_free_q <= free_next_eff != msp_pkg::LINK_NULL;
				end else begin
					mark_q <= mark_q + LINK_W'(1);
				end
				for (int s = 0; s < NS; s++) begin
					if (sel_hit[s]) begin
						top_valid_q[s] <= 1'b1;
					end
				end
			end
			if (fire && pop_ok) begin
				free_head_q <= {1'b0, cur_ptr};
				for (int s = 0; s < NS; s++) begin
					if (sel_hit[s]) begin
						top_valid_q[s] <= cur_next != msp_pkg::LINK_NULL;
						pend_stk_q[s]  <= cur_next != msp_pkg::LINK_NULL;
					end
				end
			end
		end
	end

	// Payload registers and caches
	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			req_s1 <= req;
		end
		if (fire) begin
			rsp_q <= res;
		end
		// merge last cycle's refill; the current operation takes precedence below
		for (int s = 0; s < NS; s++) begin
			if (pend_stk_q[s]) begin
				top_entry_q[s] <= rd_entry_q;
				top_next_q[s]  <= rd_next_q;
			end
		end
		if (pend_free_q) begin
			free_next_q <= rd_next_q;
		end
		if (fire && push_ok) begin
			for (int s = 0; s < NS; s++) begin
				if (sel_hit[s]) begin
					top_ptr_q[s]   <= new_node;
					top_entry_q[s] <= push_entry;
					top_next_q[s]  <= push_link;
				end
			end
		end
		if (fire && pop_ok) begin
			free_next_q <= free_head_q;
			for (int s = 0; s < NS; s++) begin
				if (sel_hit[s]) begin
					top_ptr_q[s] <= cur_next[IDX_W-1:0];
				end
			end
		end
	end

	// Checks
	a_mark_range: assert property (@(posedge clk) disable iff (!arst_n)
		mark_q <= msp_pkg::LINK_NULL)
		else $error("never-used mark beyond pool");

	a_free_below_mark: assert property (@(posedge clk) disable iff (!arst_n)
		free_head_q == msp_pkg::LINK_NULL || free_head_q < mark_q)
		else $error("free head points at a never-used node");

	a_one_refill: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({pend_free_q, pend_stk_q}))
		else $error("more than one refill pending");

	a_pop_frees: assert property (@(posedge clk) disable iff (!arst_n)
		fire && pop_ok |=> free_head_q == {1'b0, $past(cur_ptr)})
		else $error("popped node not returned to free list");

	a_mark_step: assert property (@(posedge clk) disable iff (!arst_n)
		fire && push_ok && !use_free |=> mark_q == $past(mark_q) + LINK_W'(1))
		else $error("never-used mark did not advance");

endmodule
